// ===== sv/mlr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared types, constants and codes for the mask label recoder.
// ----------------------------------------------------------------------------
package mlr_pkg;

    // label and table geometry
    localparam int LABEL_W     = 16;
    localparam int TABLE_DEPTH = 32768;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam logic [LABEL_W:0]   TABLE_LIMIT = (LABEL_W+1)'(TABLE_DEPTH);
    localparam logic [LABEL_W-1:0] LABEL_SAT   = {LABEL_W{1'b1}};
    localparam logic [LABEL_W-1:0] LABEL_FIRST = LABEL_W'(1);

    // epoch marks stand in for the per-entry valid bits of the remap table
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

    // queue sizes (powers of two)
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_AW    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 32;
    localparam logic [CFG_IW-1:0] CFG_SELECT_MIN   = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_SELECT_MAX   = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_ALL_POSITIVE = 2'd2;

    // input mode codes
    localparam logic [1:0] MODE_VOXEL        = 2'd0;
    localparam logic [1:0] MODE_NEW_MASK     = 2'd1;
    localparam logic [1:0] MODE_RESET_LABELS = 2'd2;

    // request payloads
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] mask_value;
        logic [LABEL_W-1:0] current_label;
    } t_in_item;

    typedef struct packed {
        logic [LABEL_W-1:0] new_label;
        logic               write_back;
        logic               label_out_of_table;
        logic               labels_exhausted;
        logic [LABEL_W-1:0] highest_label;
    } t_out_item;

    // classified command from front to back
    typedef enum logic [1:0] {
        CMD_PASS         = 2'd0,
        CMD_LOOKUP       = 2'd1,
        CMD_NEW_MASK     = 2'd2,
        CMD_RESET_LABELS = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic               oot;
        logic [LABEL_W-1:0] cur_label;
    } t_cmd;

    // remap table word
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [LABEL_W-1:0] target;
    } t_tab_word;

endpackage

`default_nettype wire

// ===== sv/mask_label_recoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mask_label_recoder
// Relabels voxels of successive masks into one coded label volume.
// ----------------------------------------------------------------------------
// Requests enter through push/full: one per voxel with mode, mask value and
// the label now stored at the voxel. Mode new-mask starts a fresh remap
// table, mode reset-labels also restarts label numbering at 1.
// Results leave through empty/pop in request order, exactly one per request:
// the label to write back, flags and the highest label handed out.
// Throughput is one request per cycle unless the full result queue or a
// clearing pass holds it; the back stage does the table read-modify-write,
// with the write forwarded to the next read. A stalled receiver fills the
// 2-entry result queue, then the back stage holds and the 4-entry command
// queue fills until full rises.
// Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data while idle.
// After reset the block runs a clearing pass over all TABLE_DEPTH (32768)
// remap table entries with full held high. The same pass runs again
// after every 255th new-mask or reset-labels request, when the epoch mark
// wraps.
// ----------------------------------------------------------------------------
module mask_label_recoder
    import mlr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire t_in_item          i_in,
    output logic                   empty,
    input  wire logic              pop,
    output t_out_item              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic cmdq_full;
    logic cmdq_valid;
    logic cmdq_pop;
    logic clearing;

    assign full = cmdq_full || clearing;

    // classification
    mlr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .o_cmd       (front_cmd)
    );

    // decoupling queue
    mlr_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && !full),
        .i_cmd   (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmdq_pop),
        .o_valid (cmdq_valid),
        .o_cmd   (head_cmd)
    );

    // table and label back end
    mlr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmdq_valid),
        .i_cmd       (head_cmd),
        .o_cmd_pop   (cmdq_pop),
        .o_clearing  (clearing),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

// ===== sv/mlr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_front
// Configuration registers and classification of incoming voxel requests.
// ----------------------------------------------------------------------------
module mlr_front
    import mlr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CFG_IW-1:0] i_cfg_index,
    input  wire logic [CFG_DW-1:0] i_cfg_data,
    input  wire t_in_item          i_in,
    output t_cmd                   o_cmd
);

    logic signed [31:0] r_select_min;
    logic signed [31:0] r_select_max;
    logic               r_all_positive;

    logic               sel;
    logic               oot;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_min   <= 32'sd1;
            r_select_max   <= 32'sh7FFF_FFFF;
            r_all_positive <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SELECT_MIN:   r_select_min   <= $signed(i_cfg_data);
                CFG_SELECT_MAX:   r_select_max   <= $signed(i_cfg_data);
                CFG_ALL_POSITIVE: r_all_positive <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // voxel selection and table range check
    always_comb begin
        if (r_all_positive) begin
            sel = i_in.mask_value > 32'sd0;
        end else begin
            sel = (i_in.mask_value != 32'sd0) && (i_in.mask_value >= r_select_min)
                  && (i_in.mask_value <= r_select_max);
        end
        oot = {1'b0, i_in.current_label} >= TABLE_LIMIT;
    end

    // command decode
    always_comb begin
        o_cmd.cur_label = i_in.current_label;
        o_cmd.oot       = 1'b0;
        o_cmd.kind      = CMD_PASS;
        unique case (i_in.mode)
            MODE_VOXEL: begin
                if (sel && oot) begin
                    o_cmd.oot = 1'b1;
                end else if (sel) begin
                    o_cmd.kind = CMD_LOOKUP;
                end
            end
            MODE_NEW_MASK:     o_cmd.kind = CMD_NEW_MASK;
            MODE_RESET_LABELS: o_cmd.kind = CMD_RESET_LABELS;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/mlr_cmd_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_cmd_fifo
// Short command queue between the classifying front and the table back end.
// ----------------------------------------------------------------------------
module mlr_cmd_fifo
    import mlr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd               r_q [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0] r_wptr;
    logic [CMDQ_AW-1:0] r_rptr;
    logic [CMDQ_CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = r_count == CMDQ_CW'(CMDQ_DEPTH);
    assign o_valid = r_count != '0;
    assign o_cmd   = r_q[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + CMDQ_AW'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + CMDQ_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CMDQ_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CMDQ_CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== sv/mlr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mlr_back
// Remap table lookup with forwarding, label counter, epoch clearing and
// result queue.
// ----------------------------------------------------------------------------
module mlr_back
    import mlr_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_clearing,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_out_item o_out
);

    // remap table: target label plus epoch mark
    t_tab_word          mem [TABLE_DEPTH];

    logic               r_b_valid;
    t_cmd               r_b_cmd;
    t_tab_word          r_rd_word;
    logic               r_fwd_hit;
    t_tab_word          r_fwd_word;

    logic [EPOCH_W-1:0] r_epoch;
    logic [LABEL_W-1:0] r_next_free;
    logic               r_clearing;
    logic [TAB_AW-1:0]  r_clr_addr;

    t_out_item          r_rq [RESQ_DEPTH];
    logic [RESQ_AW-1:0] r_rq_wptr;
    logic [RESQ_AW-1:0] r_rq_rptr;
    logic [RESQ_CW-1:0] r_rq_count;

    t_tab_word          entry;
    logic               hit;
    t_out_item          res;
    logic [EPOCH_W-1:0] n_epoch;
    logic [LABEL_W-1:0] n_next_free;
    logic               tab_we;
    logic               start_clear;
    logic               rq_full;
    logic               retire;
    logic               load;
    logic               rq_pop;
    logic               mem_we;
    logic [TAB_AW-1:0]  mem_waddr;
    t_tab_word          mem_wdata;
    logic [TAB_AW-1:0]  mem_raddr;

    // resolve the command in the back stage
    always_comb begin
        entry       = r_fwd_hit ? r_fwd_word : r_rd_word;
        hit         = entry.epoch == r_epoch;
        n_epoch     = r_epoch;
        n_next_free = r_next_free;
        tab_we      = 1'b0;
        start_clear = 1'b0;

        res.new_label          = r_b_cmd.cur_label;
        res.write_back         = 1'b0;
        res.label_out_of_table = r_b_cmd.oot;
        res.labels_exhausted   = 1'b0;

        unique case (r_b_cmd.kind) inside
            CMD_LOOKUP: begin
                if (hit) begin
                    res.new_label  = entry.target;
                    res.write_back = 1'b1;
                end else if (r_next_free == LABEL_SAT) begin
                    res.labels_exhausted = 1'b1;
                end else begin
                    tab_we         = 1'b1;
                    res.new_label  = r_next_free;
                    res.write_back = 1'b1;
                    n_next_free    = r_next_free + LABEL_W'(1);
                end
            end
            CMD_NEW_MASK, CMD_RESET_LABELS: begin
                // a new epoch invalidates every table entry at once
                if (r_epoch == EPOCH_MAX) begin
                    start_clear = 1'b1;
                    n_epoch     = EPOCH_FIRST;
                end else begin
                    n_epoch = r_epoch + EPOCH_W'(1);
                end
                if (r_b_cmd.kind == CMD_RESET_LABELS) begin
                    n_next_free = LABEL_FIRST;
                end
            end
            default: ;
        endcase

        res.highest_label = n_next_free - LABEL_W'(1);
    end

    // stage handshakes
    assign rq_full    = r_rq_count == RESQ_CW'(RESQ_DEPTH);
    assign retire     = r_b_valid && !rq_full;
    assign load       = i_cmd_valid && !r_clearing && (!r_b_valid || retire)
                        && !(retire && start_clear);
    assign o_cmd_pop  = load;
    assign o_clearing = r_clearing;

    // table write port: clearing pass or new assignment
    assign mem_we    = r_clearing || (retire && tab_we);
    assign mem_waddr = r_clearing ? r_clr_addr : r_b_cmd.cur_label[TAB_AW-1:0];
    assign mem_wdata = r_clearing ? t_tab_word'('0) : t_tab_word'({r_epoch, r_next_free});
    assign mem_raddr = i_cmd.cur_label[TAB_AW-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_epoch     <= EPOCH_FIRST;
            r_next_free <= LABEL_FIRST;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            if (load) begin
                r_b_valid <= 1'b1;
            end else if (retire) begin
                r_b_valid <= 1'b0;
            end
            if (retire) begin
                r_epoch     <= n_epoch;
                r_next_free <= n_next_free;
            end
            if (retire && start_clear) begin
                r_clearing <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clearing) begin
                r_clr_addr <= r_clr_addr + TAB_AW'(1);
                if (r_clr_addr == TAB_AW'(TABLE_DEPTH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // table memory with registered read and one-deep forwarding
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (load) begin
            r_b_cmd    <= i_cmd;
            r_rd_word  <= mem[mem_raddr];
            r_fwd_hit  <= mem_we && (mem_waddr == mem_raddr);
            r_fwd_word <= mem_wdata;
        end
    end

    // result queue
    assign o_empty = r_rq_count == '0;
    assign o_out   = r_rq[r_rq_rptr];
    assign rq_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wptr  <= '0;
            r_rq_rptr  <= '0;
            r_rq_count <= '0;
        end else begin
            if (retire) begin
                r_rq_wptr <= r_rq_wptr + RESQ_AW'(1);
            end
            if (rq_pop) begin
                r_rq_rptr <= r_rq_rptr + RESQ_AW'(1);
            end
            if (retire && !rq_pop) begin
                r_rq_count <= r_rq_count + RESQ_CW'(1);
            end else if (rq_pop && !retire) begin
                r_rq_count <= r_rq_count - RESQ_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (retire) begin
            r_rq[r_rq_wptr] <= res;
        end
    end

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mask label recoder.
// ----------------------------------------------------------------------------
// A scoreboard class models the remap table, the label counter and the
// selection registers. It predicts one result for every accepted request
// and compares each popped result with the oldest prediction, field by field.
// The stimulus starts with short directed cases. Random mask sequences
// follow, under several register settings and with idle and stall patterns
// on both sides. Near the end the receiver holds off while the queues fill,
// then the sender waits for every result before a last burst.
// ----------------------------------------------------------------------------
module tb_top;
    import mlr_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 20;
    localparam int INT_MIN = 32'sh8000_0000;
    localparam int INT_MAX = 32'sh7fff_ffff;

    // label volume model with per-mask stamps instead of clearing the table
    class recoder_scoreboard;
        int sel_min;
        int sel_max;
        bit all_pos;
        logic [LABEL_W-1:0] target_of [TABLE_DEPTH];
        int stamp_of [TABLE_DEPTH];
        int mask_stamp;
        int unsigned next_label;
        t_out_item label_q[$];
        int errors;
        int shown;
        int n_req, n_res, n_wb, n_oot, n_exh;

        function new();
            sel_min = 1;
            sel_max = INT_MAX;
            all_pos = 1'b0;
            mask_stamp = 1;
            next_label = 1;
            errors = 0;
            shown = 0;
            n_req = 0;
            n_res = 0;
            n_wb = 0;
            n_oot = 0;
            n_exh = 0;
        endfunction

        function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_SELECT_MIN:   sel_min = val;
                CFG_SELECT_MAX:   sel_max = val;
                CFG_ALL_POSITIVE: all_pos = val[0];
                default: ;
            endcase
        endfunction

        // predict the result of one accepted request
        function void note_request(t_in_item it);
            t_out_item res;
            int mv;
            int unsigned cur;
            bit picked;
            mv = it.mask_value;
            cur = it.current_label;
            res = '0;
            res.new_label = it.current_label;
            n_req++;
            case (it.mode)
                MODE_NEW_MASK: mask_stamp++;
                MODE_RESET_LABELS: begin
                    mask_stamp++;
                    next_label = 1;
                end
                MODE_VOXEL: begin
                    if (all_pos)
                        picked = (mv > 0);
                    else
                        picked = (mv != 0) && (mv >= sel_min) && (mv <= sel_max);
                    if (picked) begin
                        if (cur >= TABLE_DEPTH) begin
                            res.label_out_of_table = 1'b1;
                        end else if (stamp_of[cur] == mask_stamp) begin
                            res.new_label = target_of[cur];
                            res.write_back = 1'b1;
                        end else if (next_label >= LABEL_SAT) begin
                            res.labels_exhausted = 1'b1;
                        end else begin
                            target_of[cur] = LABEL_W'(next_label);
                            stamp_of[cur] = mask_stamp;
                            res.new_label = LABEL_W'(next_label);
                            res.write_back = 1'b1;
                            next_label++;
                        end
                    end
                end
                default: ;
            endcase
            res.highest_label = LABEL_W'(next_label - 1);
            n_wb += res.write_back;
            n_oot += res.label_out_of_table;
            n_exh += res.labels_exhausted;
            label_q = {label_q, res};
        endfunction

        // compare one popped result with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item exp_res;
            n_res++;
            if (label_q.size() == 0) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("unexpected result %0d: label %0d wb %0b oot %0b exh %0b high %0d",
                             n_res, got.new_label, got.write_back, got.label_out_of_table,
                             got.labels_exhausted, got.highest_label);
                end
                return;
            end
            exp_res = label_q.pop_front();
            if (got.new_label !== exp_res.new_label ||
                got.write_back !== exp_res.write_back ||
                got.label_out_of_table !== exp_res.label_out_of_table ||
                got.labels_exhausted !== exp_res.labels_exhausted ||
                got.highest_label !== exp_res.highest_label) begin
                errors++;
                if (shown < 10) begin
                    shown++;
                    $display("mismatch result %0d: exp label %0d wb %0b oot %0b exh %0b high %0d",
                             n_res, exp_res.new_label, exp_res.write_back,
                             exp_res.label_out_of_table, exp_res.labels_exhausted,
                             exp_res.highest_label);
                    $display("                   got label %0d wb %0b oot %0b exh %0b high %0d",
                             got.new_label, got.write_back, got.label_out_of_table,
                             got.labels_exhausted, got.highest_label);
                end
            end
        endfunction

        function int pending();
            return label_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    t_in_item i_in = '0;
    logic empty;
    logic pop = 1'b0;
    t_out_item o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [CFG_DW-1:0] i_cfg_data = '0;

    recoder_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;

    // selection range the mask value picker aims at
    int cur_lo = 1;
    int cur_hi = INT_MAX;

    int label_pool [8];

    mask_label_recoder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in       (i_in),
        .empty      (empty),
        .pop        (pop),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: sample at rising edge, decide pop at falling edge
    always begin
        @(posedge i_clk);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_out);
        @(negedge i_clk);
        if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // offer one request, with random idle cycles ahead of it
    task automatic send_req(input logic [1:0] mode, input logic [31:0] mask,
                            input logic [LABEL_W-1:0] label);
        t_in_item it;
        it.mode = mode;
        it.mask_value = mask;
        it.current_label = label;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sb.note_request(it);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // write all three registers while the block is idle
    task automatic apply_setting(input int lo, input int hi, input bit allpos);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SELECT_MIN;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_index <= CFG_SELECT_MAX;
        i_cfg_data <= hi;
        @(negedge i_clk);
        i_cfg_index <= CFG_ALL_POSITIVE;
        i_cfg_data <= {31'b0, allpos};
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(CFG_SELECT_MIN, lo);
        sb.set_reg(CFG_SELECT_MAX, hi);
        sb.set_reg(CFG_ALL_POSITIVE, {31'b0, allpos});
        cur_lo = allpos ? 1 : lo;
        cur_hi = allpos ? INT_MAX : hi;
        @(negedge i_clk);
    endtask

    // mask value biased toward the selection range and its edges
    function automatic logic [31:0] pick_mask();
        int unsigned r;
        longint span;
        longint unsigned rnd;
        r = $urandom_range(99);
        if (r < 35 && cur_lo <= cur_hi) begin
            span = longint'(cur_hi) - longint'(cur_lo) + 1;
            rnd = {$urandom, $urandom};
            return 32'(longint'(cur_lo) + longint'(rnd % longint'(span)));
        end
        if (r < 50) return 32'($urandom_range(400)) - 32'd200;
        if (r < 62) return $urandom;
        if (r < 67) return 32'd0;
        if (r < 72) return cur_lo;
        if (r < 77) return cur_hi;
        if (r < 81) return cur_lo - 1;
        if (r < 85) return cur_hi + 1;
        if (r < 90) return INT_MIN;
        if (r < 95) return INT_MAX;
        return ($urandom_range(1) != 0) ? 32'd1 : 32'hffff_ffff;
    endfunction

    // random mask sequences: mostly a mask start, then a run of voxels mostly on a small label set
    task automatic run_masks(input int n_items);
        int sent;
        int run;
        int k;
        int unsigned r;
        logic [1:0] md;
        logic [LABEL_W-1:0] lbl;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 10)
                send_req(MODE_RESET_LABELS, $urandom, LABEL_W'($urandom));
            else if (r < 85)
                send_req(MODE_NEW_MASK, $urandom, LABEL_W'($urandom));
            for (k = 0; k < 8; k++) begin
                r = $urandom_range(99);
                if (r < 80)
                    label_pool[k] = $urandom_range(63);
                else if (r < 95)
                    label_pool[k] = $urandom_range(TABLE_DEPTH - 1);
                else
                    label_pool[k] = $urandom_range(65535, TABLE_DEPTH);
            end
            run = $urandom_range(40, 3);
            for (k = 0; k < run; k++) begin
                r = $urandom_range(99);
                if (r < 3)
                    md = MODE_UNUSED;
                else if (r < 5)
                    md = 2'($urandom);
                else
                    md = MODE_VOXEL;
                r = $urandom_range(99);
                if (r < 70)
                    lbl = LABEL_W'(label_pool[$urandom_range(7)]);
                else if (r < 90)
                    lbl = LABEL_W'($urandom_range(TABLE_DEPTH - 1));
                else
                    lbl = LABEL_W'($urandom);
                send_req(md, pick_mask(), lbl);
                sent++;
            end
        end
    endtask

    initial begin : main
        int n_total;

        // reset, then the block runs its table clearing pass with full high
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed cases, first under the reset register values, then with all-positive selection
        send_req(MODE_RESET_LABELS, 32'd0, 16'd0);
        send_req(MODE_VOXEL, 32'd1, 16'd5);             // first miss
        send_req(MODE_VOXEL, INT_MAX, 16'd5);           // hit
        send_req(MODE_VOXEL, 32'd0, 16'd7);             // zero never selects
        send_req(MODE_VOXEL, 32'hffff_ffff, 16'd7);     // below range
        send_req(MODE_VOXEL, INT_MIN, 16'd7);
        send_req(MODE_VOXEL, 32'd5, 16'd0);
        send_req(MODE_VOXEL, 32'd5, 16'(TABLE_DEPTH - 1));
        send_req(MODE_VOXEL, 32'd5, 16'(TABLE_DEPTH));  // label outside table
        send_req(MODE_VOXEL, 32'd5, 16'hffff);
        send_req(MODE_UNUSED, 32'd5, 16'd9);            // unused mode
        send_req(MODE_VOXEL, 32'd5, 16'd9);
        send_req(MODE_NEW_MASK, 32'd5, 16'd5);          // table cleared, counter kept
        send_req(MODE_VOXEL, 32'd5, 16'd5);
        send_req(MODE_VOXEL, INT_MAX, 16'd0);
        apply_setting(INT_MIN, INT_MAX, 1'b1);
        send_req(MODE_VOXEL, 32'd1, 16'd100);
        send_req(MODE_VOXEL, 32'hffff_ffff, 16'd100);
        send_req(MODE_VOXEL, 32'd0, 16'd101);
        send_req(MODE_VOXEL, INT_MAX, 16'd101);
        send_req(MODE_VOXEL, INT_MIN, 16'd102);

        // random phases, each under its own setting and idle pattern
        apply_setting(INT_MIN, INT_MAX, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        run_masks(230);

        apply_setting(-100, 100, 1'b0);
        send_idle_pct = 87;
        recv_stall_pct = 0;
        run_masks(230);

        apply_setting($urandom, $urandom, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 87;
        run_masks(230);

        apply_setting(7, 40, 1'b0);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        run_masks(170);

        // receiver holds off while requests keep coming, so full must rise
        apply_setting(INT_MAX, INT_MAX, 1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 10;
        @(posedge i_clk);
        hold_left = 80;
        @(negedge i_clk);
        run_masks(40);

        // sender pauses until every result is back, then a last burst
        wait_drained();
        apply_setting(INT_MIN, -1, 1'b0);
        run_masks(40);

        // drain and let any stray result show up
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        n_total = sb.n_req;
        $display("requests %0d, results %0d, relabeled %0d, out of table %0d, exhausted %0d",
                 n_total, sb.n_res, sb.n_wb, sb.n_oot, sb.n_exh);
        $display("mismatches %0d, results still expected %0d, cycles %0d",
                 sb.errors, sb.pending(), cycle_count);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/mlr_pkg.sv
sv/mlr_front.sv
sv/mlr_cmd_fifo.sv
sv/mlr_back.sv
sv/mask_label_recoder.sv
verif/tb_top.sv
